/* rtl/core/pcm_pkg.sv */
// ----------------------------------------------------------------------------
// Palette color match package
// Shared widths, codes and reset values of the palette color match block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 256;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned COLOR_W = 3 * CHAN_W;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned SQ_W = 2 * CHAN_W;
	localparam int unsigned DIST_W = SQ_W + 2;
	localparam int unsigned KIND_W = 2;

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [KIND_W-1:0] match_kind_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_FIND = 1'b1;

	localparam logic CFG_ALLOC_FIRST = 1'b0;
	localparam logic CFG_ALLOC_LAST = 1'b1;

	localparam match_kind_t KIND_MARKER = 2'd0;
	localparam match_kind_t KIND_EXACT = 2'd1;
	localparam match_kind_t KIND_ALLOC = 2'd2;
	localparam match_kind_t KIND_NEAREST = 2'd3;

	localparam color_t FREE_MARKER = 24'h656565;
	localparam index_t MARKER_INDEX = 8'd254;
	localparam index_t ALLOC_FIRST_RST = 8'd140;
	localparam index_t ALLOC_LAST_RST = 8'd247;

endpackage

`default_nettype wire

/* rtl/core/palette_color_match_alloc.sv */
// ----------------------------------------------------------------------------
// Palette color match and allocate
// Keeps a palette of RGB colors; a find returns the reserved marker index,
// the first exact entry, a newly claimed free entry, or the nearest entry.
//
// Channel   Handshake              Payload
// in        in_valid / in_stall    opcode, entry_index, red, green, blue
// out       out_valid / out_stall  color_index, match_kind
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A find of the marker color skips the scan. Any other find reads one
// palette entry per cycle through the single read port of the palette RAM.
// Reset clears control state only; the palette RAM is not cleared.
// A finished result waits in the output register while new loads are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_color_match_alloc #(
	parameter int unsigned PALETTE_ENTRIES = pcm_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 opcode,
	input  wire pcm_pkg::index_t      entry_index,
	input  wire pcm_pkg::chan_t       red,
	input  wire pcm_pkg::chan_t       green,
	input  wire pcm_pkg::chan_t       blue,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output pcm_pkg::index_t           color_index,
	output pcm_pkg::match_kind_t      match_kind,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_index,
	input  wire pcm_pkg::index_t      cfg_data
);

	import pcm_pkg::*;

	localparam int unsigned IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	index_t            alloc_first_q;
	index_t            alloc_last_q;
	color_t            color_q;
	logic              marker_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              issuing_q;

	logic              v_s1;
	logic              last_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              v_s2;
	logic              last_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [SQ_W-1:0]   sq_r_s2;
	logic [SQ_W-1:0]   sq_g_s2;
	logic [SQ_W-1:0]   sq_b_s2;
	logic              eq_s2;
	logic              free_s2;

	logic              exact_hit_q;
	logic [IDX_W-1:0]  exact_idx_q;
	logic              free_hit_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [DIST_W-1:0] best_d_q;
	logic [IDX_W-1:0]  best_idx_q;

	logic              out_valid_q;
	index_t            out_idx_q;
	match_kind_t       out_kind_q;

	logic              in_accept;
	logic              out_free;
	logic              commit;
	logic              alloc_wr;
	logic              load_wr;
	logic              rd_en;
	color_t            rd_data;
	color_t            in_color;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	color_t            wr_data;
	logic [DIST_W-1:0] dist_s2;
	index_t            res_idx;
	match_kind_t       res_kind;

	function automatic logic [SQ_W-1:0] comp_sq(input chan_t a, input chan_t b);
		chan_t d;
		d = (a > b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	assign in_color = {red, green, blue};
	assign in_accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign commit = (state_q == ST_DONE) && out_free;
	assign cfg_ready = 1'b1;

	assign load_wr = in_accept && (opcode == OP_LOAD)
		&& ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
	assign alloc_wr = commit && !marker_q && !exact_hit_q && free_hit_q;
	assign wr_en = load_wr || alloc_wr;
	assign wr_addr = alloc_wr ? free_idx_q : entry_index[IDX_W-1:0];
	assign wr_data = alloc_wr ? color_q : in_color;
	assign rd_en = (state_q == ST_SCAN) && issuing_q;

	pcm_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_ENTRIES),
		.ADDR_W(IDX_W)
	) u_palette (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(cnt_q),
		.rd_data(rd_data)
	);

	assign dist_s2 = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	always_comb begin
		if (marker_q) begin
			res_idx = MARKER_INDEX;
			res_kind = KIND_MARKER;
		end else if (exact_hit_q) begin
			res_idx = INDEX_W'(exact_idx_q);
			res_kind = KIND_EXACT;
		end else if (free_hit_q) begin
			res_idx = INDEX_W'(free_idx_q);
			res_kind = KIND_ALLOC;
		end else begin
			res_idx = INDEX_W'(best_idx_q);
			res_kind = KIND_NEAREST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_first_q <= ALLOC_FIRST_RST;
			alloc_last_q <= ALLOC_LAST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ALLOC_FIRST: alloc_first_q <= cfg_data;
				CFG_ALLOC_LAST: alloc_last_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			marker_q <= 1'b0;
			issuing_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (opcode == OP_FIND)) begin
						if (in_color == FREE_MARKER) begin
							marker_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							marker_q <= 1'b0;
							cnt_q <= '0;
							issuing_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issuing_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LAST_IDX) begin
							issuing_q <= 1'b0;
						end
					end
					if (v_s2 && last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			color_q <= in_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			last_s1 <= rd_en && (cnt_q == LAST_IDX);
			v_s2 <= v_s1;
			last_s2 <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		idx_s2 <= idx_s1;
		sq_r_s2 <= comp_sq(rd_data[23:16], color_q[23:16]);
		sq_g_s2 <= comp_sq(rd_data[15:8], color_q[15:8]);
		sq_b_s2 <= comp_sq(rd_data[7:0], color_q[7:0]);
		eq_s2 <= (rd_data == color_q);
		free_s2 <= (rd_data == FREE_MARKER) && (INDEX_W'(idx_s1) >= alloc_first_q)
			&& (INDEX_W'(idx_s1) <= alloc_last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
		end else if (in_accept) begin
			exact_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
		end else if (v_s2) begin
			if (eq_s2 && !exact_hit_q) begin
				exact_hit_q <= 1'b1;
			end
			if (free_s2 && !free_hit_q) begin
				free_hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			best_d_q <= '1;
		end else if (v_s2) begin
			if (eq_s2 && !exact_hit_q) begin
				exact_idx_q <= idx_s2;
			end
			if (free_s2 && !free_hit_q) begin
				free_idx_q <= idx_s2;
			end
			if (dist_s2 < best_d_q) begin
				best_d_q <= dist_s2;
				best_idx_q <= idx_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_idx_q <= res_idx;
			out_kind_q <= res_kind;
		end
	end

	assign out_valid = out_valid_q;
	assign color_index = out_idx_q;
	assign match_kind = out_kind_q;

`ifndef SYNTHESIS
	a_wr_when_idle_or_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_IDLE || state_q == ST_DONE))
		else $error("palette written during a scan");

	a_scan_end_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && v_s2 && last_s2) |=> (state_q == ST_DONE))
		else $error("scan ended without reaching done");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside done");

	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res_kind == KIND_ALLOC) |->
		(res_idx >= alloc_first_q && res_idx <= alloc_last_q))
		else $error("allocated entry outside allocation range");

	a_no_read_outside_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SCAN) |-> !issuing_q || state_q == ST_IDLE)
		else $error("read issue pending in done state");
`endif

endmodule

`default_nettype wire

/* rtl/core/pcm_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire
